/* rtl/sc1a_pkg.sv */
// Package for the set 1 scan code to ASCII translator.
// Holds the scan code constants, the modifier flag type and the key map tables.
// No dependencies.
`default_nettype none

package sc1a_pkg;

	localparam logic [7:0] CODE_EXTENDED = 8'hE0;
	localparam logic [7:0] CODE_RELEASE  = 8'h80;
	localparam logic [6:0] CODE_LSHIFT   = 7'h2A;
	localparam logic [6:0] CODE_RSHIFT   = 7'h36;
	localparam logic [6:0] CODE_CTRL     = 7'h1D;
	localparam logic [6:0] CODE_CAPS     = 7'h3A;
	localparam logic [6:0] CTRL_MASK     = 7'h1F;
	localparam int unsigned MAP_DEPTH    = 64;

	// Modifier state kept between scan codes.
	typedef struct packed {
		logic shift_held;
		logic ctrl_held;
		logic caps_lock;
		logic extended_pending;
	} mod_flags_t;

	// Outcome of one scan code: whether a character comes out, and which.
	typedef struct packed {
		logic       emit;
		logic [6:0] ch;
	} xlate_result_t;

	localparam logic [6:0] PLAIN_MAP [MAP_DEPTH] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] SHIFTED_MAP [MAP_DEPTH] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	function automatic logic is_alpha_char(input logic [6:0] c);
		return ((c >= 7'h41) && (c <= 7'h5A)) || ((c >= 7'h61) && (c <= 7'h7A));
	endfunction

endpackage

`default_nettype wire

/* rtl/sc1a_xlate.sv */
// Combinational translation of one scan code under the current modifier flags.
// Depends on sc1a_pkg for constants, the flag type and the key maps.
`default_nettype none

module sc1a_xlate (
	input  wire logic [7:0]            code,
	input  wire sc1a_pkg::mod_flags_t  flags,
	output sc1a_pkg::mod_flags_t       flags_next,
	output sc1a_pkg::xlate_result_t    result
);
	import sc1a_pkg::*;

	logic [6:0] made;
	logic [6:0] raw_ch;
	logic [6:0] case_ch;
	logic       letter;

	assign made    = code[6:0];
	assign raw_ch  = flags.shift_held ? SHIFTED_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
	assign letter  = is_alpha_char(raw_ch);
	// Caps flips the case of a letter; with shift held the shifted map is
	// already upper case, so the flip gives lower case back.
	assign case_ch = (flags.caps_lock && letter) ? (raw_ch ^ 7'h20) : raw_ch;

	always_comb begin
		flags_next  = flags;
		result.emit = 1'b0;
		result.ch   = (flags.ctrl_held && letter) ? (case_ch & CTRL_MASK) : case_ch;

		priority if (code == CODE_EXTENDED) begin
			flags_next.extended_pending = 1'b1;
		end else if ((code & CODE_RELEASE) != 8'h00) begin
			if ((made == CODE_LSHIFT) || (made == CODE_RSHIFT)) begin
				flags_next.shift_held = 1'b0;
			end
			if (made == CODE_CTRL) begin
				flags_next.ctrl_held = 1'b0;
			end
			flags_next.extended_pending = 1'b0;
		end else if ((made == CODE_LSHIFT) || (made == CODE_RSHIFT)) begin
			flags_next.shift_held = 1'b1;
		end else if (made == CODE_CTRL) begin
			flags_next.ctrl_held = 1'b1;
		end else if (made == CODE_CAPS) begin
			flags_next.caps_lock = ~flags.caps_lock;
		end else if (flags.extended_pending) begin
			flags_next.extended_pending = 1'b0;
		end else if (code[7:6] == 2'b00) begin
			result.emit = (raw_ch != 7'h00);
		end
	end

endmodule

`default_nettype wire

/* rtl/scancode_set1_to_ascii.sv */
// Set 1 scan code to ASCII translator, top level.
// A scan code is held in the input register, and its character then passes
// through the result register before it is presented.
// Throughput: one scan code per cycle while the result side keeps up.
// Reset (arst_n, asynchronous): all modifier flags cleared, both stages empty.
// Depends on sc1a_pkg and sc1a_xlate.
`default_nettype none

module scancode_set1_to_ascii (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] scan_code,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      ascii_char
);
	import sc1a_pkg::*;

	// Stage 1 holds the accepted scan code. The modifier flags are
	// updated at the moment that code leaves stage 1, so each request is
	// translated against the flags left by the one before it.
	logic          valid_s1;
	logic [7:0]    code_s1;
	mod_flags_t    flags_q;
	mod_flags_t    flags_next;
	xlate_result_t result;
	logic          out_valid_q;
	logic [6:0]    ascii_q;
	logic          out_free;
	logic          advance_s1;

	sc1a_xlate u_xlate (
		.code       (code_s1),
		.flags      (flags_q),
		.flags_next (flags_next),
		.result     (result)
	);

	// The result register is free when empty or being taken this cycle.
	// A request that yields no character never waits on it.
	assign out_free   = !out_valid_q || out_ready;
	assign advance_s1 = valid_s1 && (!result.emit || out_free);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_s1 <= scan_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (advance_s1) begin
			flags_q <= flags_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && result.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && result.emit) begin
			ascii_q <= result.ch;
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = ascii_q;

endmodule

`default_nettype wire

/* bench/scancode_set1_to_ascii_tb.sv */
// Self-checking bench for the set 1 scan code to ASCII translator.
// Drives scan code requests with random gaps and back-pressure, checks every character.
// Depends on sc1a_pkg and scancode_set1_to_ascii.
`timescale 1ns / 1ps

module scancode_set1_to_ascii_tb;

	// Scan code values that steer the modifier logic.
	localparam logic [7:0] SC_PREFIX  = 8'hE0;
	localparam logic [7:0] SC_BREAK   = 8'h80;
	localparam logic [7:0] SC_SHIFT_L = 8'h2A;
	localparam logic [7:0] SC_SHIFT_R = 8'h36;
	localparam logic [7:0] SC_CTRL    = 8'h1D;
	localparam logic [7:0] SC_CAPS    = 8'h3A;
	localparam int KEY_ROWS = 64;

	localparam int RANDOM_REQUESTS = 1250;
	localparam int QUIET_LIMIT     = 2000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int PRINT_CAP       = 100;

	// Key tables for the 64 press codes 0x00 to 0x3F, unshifted and shifted; a zero entry gives no character.
	localparam logic [6:0] PLAIN_KEYS [KEY_ROWS] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] SHIFT_KEYS [KEY_ROWS] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	// How a directed row is checked: by the key predictor, as "no character",
	// or against a character typed into the row.
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_CHAR
	} check_t;

	typedef struct packed {
		logic [7:0] code;
		check_t     check;
		logic [6:0] want;
	} dir_row_t;

	// Directed opening. Letter codes: 0x10 is Q, 0x1E is A, 0x2E is C.
	localparam dir_row_t DIRECTED_ROWS [25] = '{
		'{8'h00, CHK_NONE, 7'h00},             // code zero right after reset
		'{8'h1E, CHK_CHAR, 7'h61},             // plain letter
		'{8'h01, CHK_CHAR, 7'h1B},             // escape, lowest mapped code
		'{8'h7F, CHK_NONE, 7'h00},             // highest press code, unmapped
		'{8'h39, CHK_CHAR, 7'h20},             // space
		'{SC_PREFIX, CHK_NONE, 7'h00},
		'{SC_PREFIX, CHK_NONE, 7'h00},         // prefix repeated while pending
		'{8'h1E, CHK_NONE, 7'h00},             // extended press is dropped
		'{8'h1E, CHK_PREDICT, 7'h00},
		'{SC_PREFIX, CHK_NONE, 7'h00},
		'{SC_SHIFT_L, CHK_NONE, 7'h00},        // modifier keeps the prefix pending
		'{8'h10, CHK_NONE, 7'h00},             // so this press is still dropped
		'{8'h10, CHK_PREDICT, 7'h00},
		'{SC_PREFIX, CHK_NONE, 7'h00},
		'{SC_SHIFT_L | SC_BREAK, CHK_NONE, 7'h00}, // release clears shift and prefix
		'{8'h10, CHK_PREDICT, 7'h00},
		'{SC_CAPS, CHK_NONE, 7'h00},
		'{8'h10, CHK_PREDICT, 7'h00},          // caps on a letter
		'{8'h02, CHK_PREDICT, 7'h00},          // caps leaves digits alone
		'{SC_SHIFT_R, CHK_NONE, 7'h00},
		'{8'h10, CHK_PREDICT, 7'h00},          // shift undoes caps
		'{SC_SHIFT_R | SC_BREAK, CHK_NONE, 7'h00},
		'{SC_CTRL, CHK_NONE, 7'h00},
		'{8'h2E, CHK_PREDICT, 7'h00},          // ctrl masks the letter
		'{8'hFF, CHK_NONE, 7'h00}              // highest release code
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] scan_code;
	logic       out_valid;
	logic       out_ready;
	logic [6:0] ascii_char;

	// Modifier flags as the predictor sees them, and the characters still owed by the block.
	sc1a_pkg::mod_flags_t kbd;
	logic [6:0]           expected_chars [$];

	int mismatch_count;
	int quiet_cycles;
	int ready_hold;
	bit no_idle;

	scancode_set1_to_ascii dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.scan_code  (scan_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ascii_char (ascii_char)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit is_alpha(input logic [6:0] c);
		return (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A);
	endfunction

	// Applies one scan code to the predicted flags and returns 1 when a character comes out.
	function automatic bit translate_key(input logic [7:0] code, output logic [6:0] ch);
		logic [6:0] c;
		ch = 7'h00;
		if (code == SC_PREFIX) begin
			kbd.extended_pending = 1'b1;
			return 1'b0;
		end
		// Any release drops the prefix; only the shift and ctrl releases touch the other flags.
		if ((code & SC_BREAK) != 8'h00) begin
			if ((code & ~SC_BREAK) == SC_SHIFT_L || (code & ~SC_BREAK) == SC_SHIFT_R)
				kbd.shift_held = 1'b0;
			if ((code & ~SC_BREAK) == SC_CTRL)
				kbd.ctrl_held = 1'b0;
			kbd.extended_pending = 1'b0;
			return 1'b0;
		end
		// Modifier presses leave a pending prefix in place.
		if (code == SC_SHIFT_L || code == SC_SHIFT_R) begin
			kbd.shift_held = 1'b1;
			return 1'b0;
		end
		if (code == SC_CTRL) begin
			kbd.ctrl_held = 1'b1;
			return 1'b0;
		end
		if (code == SC_CAPS) begin
			kbd.caps_lock = ~kbd.caps_lock;
			return 1'b0;
		end
		if (kbd.extended_pending) begin
			kbd.extended_pending = 1'b0;
			return 1'b0;
		end
		if (code >= KEY_ROWS)
			return 1'b0;
		c = kbd.shift_held ? SHIFT_KEYS[code[5:0]] : PLAIN_KEYS[code[5:0]];
		if (c == 7'h00)
			return 1'b0;
		// Caps flips letter case, which is bit 5; with shift held this turns
		// the shifted capital back into lower case.
		if (kbd.caps_lock && is_alpha(c))
			c = c ^ 7'h20;
		if (kbd.ctrl_held && is_alpha(c))
			c = c & 7'h1F;
		ch = c;
		return 1'b1;
	endfunction

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Random scan codes, weighted toward typing: plenty of mapped presses, modifier
	// presses and releases, prefixes, plus stray releases, unmapped codes and noise.
	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 8'($urandom_range(8'h3F));
		if (r < 62) begin
			case ($urandom_range(3))
				0: return SC_SHIFT_L;
				1: return SC_SHIFT_R;
				2: return SC_CTRL;
				default: return SC_CAPS;
			endcase
		end
		if (r < 74) begin
			case ($urandom_range(2))
				0: return SC_SHIFT_L | SC_BREAK;
				1: return SC_SHIFT_R | SC_BREAK;
				default: return SC_CTRL | SC_BREAK;
			endcase
		end
		if (r < 82)
			return SC_PREFIX;
		if (r < 88)
			return 8'($urandom_range(8'hFF, 8'h80));
		if (r < 94)
			return 8'($urandom_range(8'h7F, 8'h40));
		return 8'($urandom_range(8'hFF));
	endfunction

	task automatic report_mismatch(input string what, input logic [6:0] want,
			input logic [6:0] got);
		if (mismatch_count < PRINT_CAP)
			$display("%0t: %s: expected 0x%02h, got 0x%02h", $time, what, want, got);
		mismatch_count++;
	endtask

	// Offers one request and waits for the handshake. The predictor runs at the accepting
	// edge; a zero gap keeps in_valid high straight into the next request.
	task automatic send_code(input logic [7:0] code, input int gap, input check_t check,
			input logic [6:0] want);
		logic [6:0] ch;
		bit         emits;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		scan_code <= code;
		do
			@(posedge clk);
		while (!in_ready);
		emits = translate_key(code, ch);
		case (check)
			CHK_PREDICT: begin
				if (emits)
					expected_chars.push_back(ch);
			end
			CHK_CHAR: expected_chars.push_back(want);
			default: ;
		endcase
	endtask

	// Stops sending until every owed character has come out. At least one edge passes,
	// so in_valid is never lowered and raised in the same step.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_chars.size() != 0);
	endtask

	// Receiver: out_ready holds a random level for a random number of cycles,
	// except in the stretches where neither side idles.
	always @(posedge clk) begin
		if (no_idle) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold--;
		end else begin
			out_ready  <= ($urandom_range(9) < 7);
			ready_hold = idle_len();
		end
	end

	// Every character leaving the block is matched against the oldest one owed.
	always @(posedge clk) begin
		logic [6:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch("character with no scan code behind it", 7'h00, ascii_char);
			end else begin
				want = expected_chars.pop_front();
				if (ascii_char !== want)
					report_mismatch("ascii_char", want, ascii_char);
			end
		end
	end

	// Watchdog: too many cycles in a row without a handshake on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, QUIET_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		in_valid       <= 1'b0;
		scan_code      <= 8'h00;
		out_ready      <= 1'b0;
		arst_n         <= 1'b0;
		no_idle        <= 1'b0;
		kbd            = '0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		ready_hold     = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening, walked row by row.
		foreach (DIRECTED_ROWS[i])
			send_code(DIRECTED_ROWS[i].code, idle_len(), DIRECTED_ROWS[i].check,
				DIRECTED_ROWS[i].want);
		hold_until_drained();

		// Random typing. Every hundred requests the idling mode is redrawn, and now and
		// then the sender waits for the block to empty before going on.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 100 == 0)
				no_idle <= ($urandom_range(3) == 0);
			if (n % 300 == 150)
				hold_until_drained();
			send_code(pick_code(), no_idle ? 0 : idle_len(), CHK_PREDICT, 7'h00);
		end

		// Let the pipeline settle so that any stray character still shows up.
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
rtl/sc1a_pkg.sv
rtl/sc1a_xlate.sv
rtl/scancode_set1_to_ascii.sv
bench/scancode_set1_to_ascii_tb.sv
